// ===== rtl/fpa_pkg.sv =====
package fpa_pkg;

  localparam int WordWidth = 32;
  localparam int FracBits = 8;
  // quotient bits needed: numerator magnitude is at most 2^(W-1+F), plus one round bit
  localparam int QuoBits = WordWidth + FracBits + 1;
  localparam int NumBits = WordWidth + FracBits + 1;
  localparam int DenBits = WordWidth + 1;
  localparam int ProdBits = 2 * WordWidth;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_MIN = 3'd4,
    KIND_MAX = 3'd5,
    KIND_INC = 3'd6,
    KIND_DEC = 3'd7
  } kind_t;

  // context carried along the divider chain with each beat
  typedef struct packed {
    logic                 valid;
    logic [2:0]           kind;
    logic                 neg;
    logic                 dz;
    logic                 less;
    logic                 equal;
    logic                 greater;
    logic [WordWidth-1:0] simple;
    logic                 simple_ovf;
    logic [ProdBits-1:0]  prod;
  } ctx_t;

  // one restoring division step: remainder, denominator, numerator bits still to shift in and quotient so far
  typedef struct packed {
    logic [DenBits:0]    rem;
    logic [DenBits-1:0]  den;
    logic [NumBits-1:0]  num;
    logic [QuoBits-1:0]  quo;
  } div_t;

endpackage

// ===== rtl/fixed_point_q24_8_alu.sv =====
// fixed-point q24.8 alu, one operation accepted every cycle, busy is always low
// every kind passes the first stage register and the whole divider cell chain from start to done
// the chain of restoring divider cells sets the pipeline depth, one quotient bit per cell
// the multiply is registered once ahead of the chain and rides along with the beat
// rst is synchronous and clears only the valid bits; the receiver cannot stall
module fixed_point_q24_8_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic        done,
  output logic signed [31:0] result_raw,
  output logic        a_less,
  output logic        a_equal,
  output logic        a_greater,
  output logic        overflow,
  output logic        divide_by_zero
);

  localparam int W = fpa_pkg::WordWidth;
  localparam int F = fpa_pkg::FracBits;
  localparam int N = fpa_pkg::QuoBits;

  fpa_pkg::ctx_t ctx [N+1];
  fpa_pkg::div_t dv [N+1];

  logic [W-1:0] mag_a, mag_b;
  logic signed [W:0] sum, dif, inc, dec;
  logic [W-1:0] simple;
  logic simple_ovf;
  logic signed [W-1:0] wmax, wmin;

  assign busy = 1'b0;
  assign wmax = {1'b0, {(W-1){1'b1}}};
  assign wmin = {1'b1, {(W-1){1'b0}}};
  assign mag_a = operand_a[W-1] ? (~operand_a + 1'b1) : operand_a;
  assign mag_b = operand_b[W-1] ? (~operand_b + 1'b1) : operand_b;

  function automatic logic [W:0] sat(input logic signed [W:0] v);
    if (v > $signed({1'b0, wmax})) sat = {1'b1, wmax};
    else if (v < $signed({1'b1, wmin})) sat = {1'b1, wmin};
    else sat = {1'b0, v[W-1:0]};
  endfunction

  always_comb begin
    logic [W:0] s;
    sum = {operand_a[W-1], operand_a} + {operand_b[W-1], operand_b};
    dif = {operand_a[W-1], operand_a} - {operand_b[W-1], operand_b};
    inc = {operand_a[W-1], operand_a} + {{W{1'b0}}, 1'b1};
    dec = {operand_a[W-1], operand_a} - {{W{1'b0}}, 1'b1};
    case (kind)
      fpa_pkg::KIND_ADD: s = sat(sum);
      fpa_pkg::KIND_SUB: s = sat(dif);
      fpa_pkg::KIND_INC: s = sat(inc);
      fpa_pkg::KIND_DEC: s = sat(dec);
      fpa_pkg::KIND_MIN: s = {1'b0, (operand_a > operand_b) ? operand_b : operand_a};
      fpa_pkg::KIND_MAX: s = {1'b0, (operand_a > operand_b) ? operand_a : operand_b};
      default: s = '0;
    endcase
    simple = s[W-1:0];
    simple_ovf = s[W];
  end

  // first stage: register the product, the compare flags, the simple result and the divider inputs
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx[0].valid <= 1'b0;
    end else begin
      ctx[0].valid <= start;
    end
    ctx[0].kind <= kind;
    ctx[0].neg <= operand_a[W-1] ^ operand_b[W-1];
    ctx[0].dz <= (kind == fpa_pkg::KIND_DIV) && (operand_b == '0);
    ctx[0].less <= operand_a < operand_b;
    ctx[0].equal <= operand_a == operand_b;
    ctx[0].greater <= operand_a > operand_b;
    ctx[0].simple <= simple;
    ctx[0].simple_ovf <= simple_ovf;
    ctx[0].prod <= mag_a * mag_b;
    // divide (2n + d) / 2d, with n = |a| << F
    dv[0].rem <= '0;
    dv[0].den <= {mag_b, 1'b0};
    dv[0].num <= {mag_a, {F{1'b0}}, 1'b0} + {{(F+1){1'b0}}, mag_b};
    dv[0].quo <= '0;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk(clk), .rst(rst),
      .ctx_in(ctx[i]), .div_in(dv[i]),
      .ctx_out(ctx[i+1]), .div_out(dv[i+1])
    );
  end

  // final stage: round, sign and saturate the product or quotient, or pass the simple result
  always_comb begin
    logic [fpa_pkg::ProdBits-1:0] q;
    logic [fpa_pkg::ProdBits:0] rq;
    logic [fpa_pkg::ProdBits:0] lim;
    fpa_pkg::ctx_t c;
    c = ctx[N];
    // (2p + 2^F) >> (F+1): half away from zero on the magnitude
    rq = ({c.prod, 1'b0} + ({{fpa_pkg::ProdBits{1'b0}}, 1'b1} << F)) >> (F + 1);
    q = (c.kind == fpa_pkg::KIND_MUL) ? rq[fpa_pkg::ProdBits-1:0]
        : {{(fpa_pkg::ProdBits-N){1'b0}}, dv[N].quo};
    lim = {{(fpa_pkg::ProdBits-W+1){1'b0}}, wmax};
    overflow = 1'b0;
    divide_by_zero = 1'b0;
    case (c.kind)
      fpa_pkg::KIND_MUL, fpa_pkg::KIND_DIV: begin
        if (c.dz) begin
          result_raw = '0;
          divide_by_zero = 1'b1;
        end else if (c.neg) begin
          if ({1'b0, q} > lim + 1'b1) begin
            result_raw = wmin;
            overflow = 1'b1;
          end else begin
            result_raw = ~q[W-1:0] + 1'b1;
          end
        end else if ({1'b0, q} > lim) begin
          result_raw = wmax;
          overflow = 1'b1;
        end else begin
          result_raw = q[W-1:0];
        end
      end
      default: begin
        result_raw = c.simple;
        overflow = c.simple_ovf;
      end
    endcase
    done = c.valid;
    a_less = c.less;
    a_equal = c.equal;
    a_greater = c.greater;
  end

endmodule

// ===== rtl/fpa_div_cell.sv =====
module fpa_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  fpa_pkg::ctx_t  ctx_in,
  input  fpa_pkg::div_t  div_in,
  output fpa_pkg::ctx_t  ctx_out,
  output fpa_pkg::div_t  div_out
);

  fpa_pkg::div_t step;
  logic [fpa_pkg::DenBits:0] trial;
  logic [fpa_pkg::DenBits+1:0] diff;

  always_comb begin
    step = div_in;
    trial = {div_in.rem[fpa_pkg::DenBits-1:0], div_in.num[fpa_pkg::NumBits-1]};
    diff = {1'b0, trial} - {2'b00, div_in.den};
    step.num = {div_in.num[fpa_pkg::NumBits-2:0], 1'b0};
    if (!diff[fpa_pkg::DenBits+1]) begin
      step.rem = diff[fpa_pkg::DenBits:0];
      step.quo = {div_in.quo[fpa_pkg::QuoBits-2:0], 1'b1};
    end else begin
      step.rem = trial;
      step.quo = {div_in.quo[fpa_pkg::QuoBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_out.valid <= 1'b0;
    end else begin
      ctx_out.valid <= ctx_in.valid;
    end
    ctx_out.kind <= ctx_in.kind;
    ctx_out.neg <= ctx_in.neg;
    ctx_out.dz <= ctx_in.dz;
    ctx_out.less <= ctx_in.less;
    ctx_out.equal <= ctx_in.equal;
    ctx_out.greater <= ctx_in.greater;
    ctx_out.simple <= ctx_in.simple;
    ctx_out.simple_ovf <= ctx_in.simple_ovf;
    ctx_out.prod <= ctx_in.prod;
    div_out <= step;
  end

endmodule

// ===== tb/sv/fixed_point_q24_8_alu_tb.sv =====
`timescale 1ns / 100ps

module fixed_point_q24_8_alu_tb;

  localparam int Latency = 1 + fpa_pkg::QuoBits;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic signed [31:0] value;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               ovf;
    logic               dz;
  } alu_out_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [2:0] kind;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  logic done;
  logic signed [31:0] result_raw;
  logic a_less;
  logic a_equal;
  logic a_greater;
  logic overflow;
  logic divide_by_zero;

  alu_out_t pending_q[$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  fixed_point_q24_8_alu dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .done(done),
    .result_raw(result_raw),
    .a_less(a_less),
    .a_equal(a_equal),
    .a_greater(a_greater),
    .overflow(overflow),
    .divide_by_zero(divide_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // apply sign to a magnitude and clamp to the 32-bit range
  function automatic logic signed [31:0] sign_clamp(input bit neg, input logic [127:0] q,
                                                    output bit ovf);
    ovf = 1'b0;
    if (neg) begin
      if (q > 128'h8000_0000) begin
        ovf = 1'b1;
        return 32'sh8000_0000;
      end
      return 32'(-$signed(q[32:0]));
    end
    if (q > 128'h7fff_ffff) begin
      ovf = 1'b1;
      return 32'sh7fff_ffff;
    end
    return $signed(q[31:0]);
  endfunction

  function automatic logic signed [31:0] clamp_sum(input logic signed [33:0] v, output bit ovf);
    ovf = 1'b0;
    if (v > 34'sh0_7fff_ffff) begin
      ovf = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -34'sh0_8000_0000) begin
      ovf = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic alu_out_t alu_predict(input fpa_pkg::kind_t k,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_out_t r;
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] q;
    bit neg;
    bit ovf;
    ma = (a < 0) ? 128'(-34'(a)) : 128'(a);
    mb = (b < 0) ? 128'(-34'(b)) : 128'(b);
    neg = (a < 0) != (b < 0);
    ovf = 1'b0;
    r = '0;
    case (k)
      fpa_pkg::KIND_ADD: r.value = clamp_sum(34'(a) + 34'(b), ovf);
      fpa_pkg::KIND_SUB: r.value = clamp_sum(34'(a) - 34'(b), ovf);
      fpa_pkg::KIND_MUL: begin
        q = ((ma * mb) * 2 + (128'd1 << fpa_pkg::FracBits)) >> (fpa_pkg::FracBits + 1);
        r.value = sign_clamp(neg, q, ovf);
      end
      fpa_pkg::KIND_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
          r.value = '0;
        end else begin
          q = (((ma << fpa_pkg::FracBits) * 2) + mb) / (mb * 2);
          r.value = sign_clamp(neg, q, ovf);
        end
      end
      fpa_pkg::KIND_MIN: r.value = (a > b) ? b : a;
      fpa_pkg::KIND_MAX: r.value = (a > b) ? a : b;
      fpa_pkg::KIND_INC: r.value = clamp_sum(34'(a) + 34'sd1, ovf);
      default:  r.value = clamp_sum(34'(a) - 34'sd1, ovf);
    endcase
    r.ovf = ovf;
    r.lt = a < b;
    r.eq = a == b;
    r.gt = a > b;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch at beat %0d: %s got %h expected %h", beats_checked, what, got, want);
  endtask

  // send one beat; random gaps between bursts, start stays high after the beat
  task automatic send_op(input fpa_pkg::kind_t k, input logic signed [31:0] a,
                         input logic signed [31:0] b);
    int gap;
    gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    operand_a <= a;
    operand_b <= b;
    pending_q.push_back(alu_predict(k, a, b));
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 && !timed_out) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(0, 1024)) - 512);
      3: return $signed(32'($urandom_range(0, 32'h40000)) - 32'h20000);
      4: return 32'sh0;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] edges[6] = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0,
                                     32'sh100, -32'sh100, 32'sh1};
    send_op(fpa_pkg::KIND_ADD, 32'sh7fff_ffff, 32'sh1);
    send_op(fpa_pkg::KIND_ADD, 32'sh8000_0000, -32'sh1);
    send_op(fpa_pkg::KIND_SUB, 32'sh8000_0000, 32'sh1);
    send_op(fpa_pkg::KIND_SUB, 32'sh7fff_ffff, 32'sh8000_0000);
    send_op(fpa_pkg::KIND_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_op(fpa_pkg::KIND_MUL, 32'sh8000_0000, 32'sh8000_0000);
    send_op(fpa_pkg::KIND_MUL, 32'sh8000_0000, 32'sh100);
    send_op(fpa_pkg::KIND_MUL, 32'sh180, -32'sh1);
    send_op(fpa_pkg::KIND_MUL, 32'sh80, 32'sh1);
    send_op(fpa_pkg::KIND_DIV, 32'sh1234, 32'sh0);
    send_op(fpa_pkg::KIND_DIV, 32'sh8000_0000, 32'sh1);
    send_op(fpa_pkg::KIND_DIV, 32'sh8000_0000, -32'sh100);
    send_op(fpa_pkg::KIND_DIV, 32'sh1, -32'sh200);
    send_op(fpa_pkg::KIND_DIV, -32'sh300, 32'sh200);
    send_op(fpa_pkg::KIND_MIN, 32'sh55, 32'sh55);
    send_op(fpa_pkg::KIND_MAX, -32'sh7, -32'sh7);
    send_op(fpa_pkg::KIND_MIN, 32'sh8000_0000, 32'sh7fff_ffff);
    send_op(fpa_pkg::KIND_MAX, 32'sh8000_0000, 32'sh7fff_ffff);
    send_op(fpa_pkg::KIND_INC, 32'sh7fff_ffff, 32'sh0);
    send_op(fpa_pkg::KIND_DEC, 32'sh8000_0000, 32'sh0);
    send_op(fpa_pkg::KIND_INC, -32'sh1, 32'sh5);
    send_op(fpa_pkg::KIND_DEC, 32'sh0, -32'sh5);
    foreach (edges[i]) send_op(fpa_pkg::KIND_DIV, edges[i], edges[(i + 1) % 6]);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_op(fpa_pkg::kind_t'($urandom_range(0, 7)), pick_operand(), pick_operand());
      if (i == count / 2) begin
        // hold off until the whole pipeline has drained
        start <= 1'b0;
        wait_drained();
      end
    end
  endtask

  task automatic test_back_to_back(input int count);
    for (int i = 0; i < count; i++) begin
      start <= 1'b1;
      kind <= fpa_pkg::kind_t'($urandom_range(0, 7));
      operand_a <= $signed($urandom());
      operand_b <= $signed($urandom());
      @(posedge clk);
      pending_q.push_back(alu_predict(fpa_pkg::kind_t'(kind), operand_a, operand_b));
      beats_sent++;
    end
    start <= 1'b0;
  endtask

  // result checker, samples at the edge that ends each result cycle
  always @(posedge clk) begin
    alu_out_t want;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", result_raw, '0);
      end else begin
        want = pending_q.pop_front();
        if (result_raw !== want.value) report_mismatch("result_raw", result_raw, want.value);
        if (a_less !== want.lt) report_mismatch("a_less", a_less, want.lt);
        if (a_equal !== want.eq) report_mismatch("a_equal", a_equal, want.eq);
        if (a_greater !== want.gt) report_mismatch("a_greater", a_greater, want.gt);
        if (overflow !== want.ovf) report_mismatch("overflow", overflow, want.ovf);
        if (divide_by_zero !== want.dz) report_mismatch("divide_by_zero", divide_by_zero, want.dz);
        beats_checked++;
      end
    end
  end

  // watchdog on cycles with no accepted beat and no result
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired");
      $display("** fixed_point_q24_8_alu: FAILED **");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    kind = fpa_pkg::KIND_ADD;
    operand_a = '0;
    operand_b = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600);
    test_back_to_back(100);
    wait_drained();
    repeat (Latency + 10) @(posedge clk);
    $display("sent %0d beats over all eight kinds, %0d results checked", beats_sent,
             beats_checked);
    $display("edges, saturation, divide by zero, ties, gaps and back-to-back streams covered");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("** fixed_point_q24_8_alu: PASSED **");
    end else begin
      $display("** fixed_point_q24_8_alu: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fpa_pkg.sv
rtl/fpa_div_cell.sv
rtl/fixed_point_q24_8_alu.sv
tb/sv/fixed_point_q24_8_alu_tb.sv
